[rtl/sxd_pkg.sv]
// Shared types and constants of the sync-word packet deframer.
// Used by the controller, the datapath and the top level; depends on nothing.
package sxd_pkg;

	localparam int BYTE_W    = 8;
	localparam int POS_W     = 5;
	localparam int STAMP_W   = 32;
	localparam int CHAN_W    = 4;
	localparam int SAMPLE_W  = 16;
	localparam int COUNT_W   = 32;
	localparam int TDATA_W   = 120;
	localparam int CFG_IDX_W = 1;
	localparam int STAMP_BYTES = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SYNC_FIRST  = 1'b0,
		REG_SYNC_SECOND = 1'b1
	} cfg_reg_t;

	localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hAA;
	localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h55;

	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_ERROR  = 1'b1;

	typedef struct packed {
		logic accept_in;
		logic rd_sample_lo;
		logic rd_sample_hi;
		logic load_good;
		logic load_err;
		logic rp_read;
		logic rp_feed;
	} cmd_t;

	typedef struct packed {
		logic done_good;
		logic done_bad;
		logic out_free;
		logic chan_last;
		logic rp_last;
	} status_t;

endpackage

[rtl/sync_xor_packet_deframer.sv]
// Top level of the sync-word packet deframer with XOR checksum.
// Uses sxd_pkg; instantiates sxd_ctrl and sxd_datapath.
//
// Channel   Direction  Carries
// s_*       in         s_tdata = rx_byte
// m_*       out        m_tuser = kind, m_tlast = last, m_tdata = result fields
// cfg_*     in         register index and value, written when cfg_wr_en is high
//
// The checksum byte of a good packet is followed per channel by ST_RD_LO, ST_RD_HI
// and ST_EMIT, as the store has a single read port. A bad checksum first loads the
// error result in ST_ERR and then replays each stored byte through ST_RP_RD and
// ST_RP_FEED. Output stalls hold the sequence where it stands. Reset is
// asynchronous and clears all control state.
module sync_xor_packet_deframer #(
	parameter int CHANNELS = 12
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,   // [7:0] rx_byte
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [sxd_pkg::TDATA_W-1:0]     m_tdata,   // [31:0] stamp, [35:32] channel,
	                                                   // [51:36] sample, [83:52] good_total,
	                                                   // [115:84] bad_total, zero pad
	output logic                            m_tuser,   // [0] kind
	output logic                            m_tlast,
	input  logic                            cfg_wr_en,
	input  logic [sxd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [7:0]                      cfg_wdata
);

	sxd_pkg::cmd_t    cmd;
	sxd_pkg::status_t status;

	logic [sxd_pkg::STAMP_W-1:0]         out_stamp;
	logic [sxd_pkg::CHAN_W-1:0]          out_channel;
	logic signed [sxd_pkg::SAMPLE_W-1:0] out_sample;
	logic [sxd_pkg::COUNT_W-1:0]         out_good;
	logic [sxd_pkg::COUNT_W-1:0]         out_bad;

	sxd_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.status  (status),
		.cmd     (cmd)
	);

	sxd_datapath #(
		.CHANNELS(CHANNELS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.rx_byte    (s_tdata),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.out_kind   (m_tuser),
		.out_stamp  (out_stamp),
		.out_channel(out_channel),
		.out_sample (out_sample),
		.out_last   (m_tlast),
		.out_good   (out_good),
		.out_bad    (out_bad)
	);

	assign m_tdata = {4'd0, out_bad, out_good, out_sample, out_channel, out_stamp};

endmodule

[rtl/sxd_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
// Stands alone; depends on nothing.
module sxd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 29
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

[rtl/sxd_ctrl.sv]
// Controller of the deframer: sequences input transfers, result readout and replay.
// Uses sxd_pkg for the command and status structs.
module sxd_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  sxd_pkg::status_t status,
	output sxd_pkg::cmd_t   cmd
);

	typedef enum logic [6:0] {
		ST_IDLE    = 7'b0000001,
		ST_RD_LO   = 7'b0000010,
		ST_RD_HI   = 7'b0000100,
		ST_EMIT    = 7'b0001000,
		ST_ERR     = 7'b0010000,
		ST_RP_RD   = 7'b0100000,
		ST_RP_FEED = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_n;

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		state_n  = state_q;
		case (state_q)
			ST_IDLE: begin
				s_tready      = 1'b1;
				cmd.accept_in = s_tvalid;
				if (status.done_good) begin
					state_n = ST_RD_LO;
				end else if (status.done_bad) begin
					state_n = ST_ERR;
				end
			end
			ST_RD_LO: begin
				cmd.rd_sample_lo = 1'b1;
				state_n          = ST_RD_HI;
			end
			ST_RD_HI: begin
				cmd.rd_sample_hi = 1'b1;
				state_n          = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.load_good = 1'b1;
					state_n       = status.chan_last ? ST_IDLE : ST_RD_LO;
				end
			end
			ST_ERR: begin
				if (status.out_free) begin
					cmd.load_err = 1'b1;
					state_n      = ST_RP_RD;
				end
			end
			ST_RP_RD: begin
				cmd.rp_read = 1'b1;
				state_n     = ST_RP_FEED;
			end
			ST_RP_FEED: begin
				cmd.rp_feed = 1'b1;
				state_n     = status.rp_last ? ST_IDLE : ST_RP_RD;
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

endmodule

[rtl/sxd_datapath.sv]
// Datapath of the deframer: sync hunter, checksum, packet store, counters, result register.
// Uses sxd_pkg and instantiates sxd_ram for the packet store.
module sxd_datapath #(
	parameter int CHANNELS = 12
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  sxd_pkg::cmd_t                     cmd,
	output sxd_pkg::status_t                  status,
	input  logic [sxd_pkg::BYTE_W-1:0]        rx_byte,
	input  logic                              cfg_wr_en,
	input  logic [sxd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sxd_pkg::BYTE_W-1:0]        cfg_wdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic                              out_kind,
	output logic [sxd_pkg::STAMP_W-1:0]       out_stamp,
	output logic [sxd_pkg::CHAN_W-1:0]        out_channel,
	output logic signed [sxd_pkg::SAMPLE_W-1:0] out_sample,
	output logic                              out_last,
	output logic [sxd_pkg::COUNT_W-1:0]       out_good,
	output logic [sxd_pkg::COUNT_W-1:0]       out_bad
);

	localparam int STORED = 5 + 2 * CHANNELS;
	localparam int ADDR_W = $clog2(STORED);
	localparam logic [sxd_pkg::POS_W-1:0] POS_CHECK = sxd_pkg::POS_W'(STORED);
	localparam logic [ADDR_W-1:0] RP_END = ADDR_W'(STORED - 1);
	localparam logic [sxd_pkg::CHAN_W-1:0] CHAN_END = sxd_pkg::CHAN_W'(CHANNELS - 1);

	logic [sxd_pkg::BYTE_W-1:0]  sync_first_q;
	logic [sxd_pkg::BYTE_W-1:0]  sync_second_q;
	logic [sxd_pkg::POS_W-1:0]   pos_q;
	logic                        saw_q;
	logic [sxd_pkg::BYTE_W-1:0]  xor_q;
	logic [sxd_pkg::STAMP_W-1:0] stamp_q;
	logic [sxd_pkg::CHAN_W-1:0]  chan_q;
	logic [ADDR_W-1:0]           rp_q;
	logic [sxd_pkg::BYTE_W-1:0]  lo_q;
	logic [sxd_pkg::COUNT_W-1:0] good_q;
	logic [sxd_pkg::COUNT_W-1:0] bad_q;
	logic                        m_tvalid_q;

	logic                        step;
	logic [sxd_pkg::BYTE_W-1:0]  cur_byte;
	logic [sxd_pkg::POS_W-1:0]   pos_dec;
	logic [ADDR_W-1:0]           wr_addr;
	logic                        wr_en;
	logic                        at_check;
	logic                        match_good;
	logic [5:0]                  lo_addr_w;
	logic [5:0]                  hi_addr_w;
	logic                        rd_en;
	logic [ADDR_W-1:0]           rd_addr;
	logic [sxd_pkg::BYTE_W-1:0]  rd_data;

	assign step     = cmd.accept_in | cmd.rp_feed;
	assign cur_byte = cmd.rp_feed ? rd_data : rx_byte;
	assign pos_dec  = pos_q - sxd_pkg::POS_W'(1);
	assign wr_addr  = pos_dec[ADDR_W-1:0];
	assign at_check = (pos_q == POS_CHECK);
	assign wr_en    = step && (pos_q != '0);
	assign match_good = (cur_byte == xor_q);

	assign lo_addr_w = 6'd4 + {1'b0, chan_q, 1'b0};
	assign hi_addr_w = 6'd5 + {1'b0, chan_q, 1'b0};
	assign rd_en     = cmd.rd_sample_lo | cmd.rd_sample_hi | cmd.rp_read;

	always_comb begin
		rd_addr = rp_q;
		if (cmd.rd_sample_lo) begin
			rd_addr = lo_addr_w[ADDR_W-1:0];
		end else if (cmd.rd_sample_hi) begin
			rd_addr = hi_addr_w[ADDR_W-1:0];
		end
	end

	assign status.done_good = cmd.accept_in && at_check && match_good;
	assign status.done_bad  = cmd.accept_in && at_check && !match_good;
	assign status.out_free  = !m_tvalid_q || m_tready;
	assign status.chan_last = (chan_q == CHAN_END);
	assign status.rp_last   = (rp_q == RP_END);

	sxd_ram #(
		.WIDTH(sxd_pkg::BYTE_W),
		.DEPTH(STORED)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(cur_byte),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= sxd_pkg::SYNC_FIRST_RST;
			sync_second_q <= sxd_pkg::SYNC_SECOND_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				sxd_pkg::REG_SYNC_FIRST:  sync_first_q  <= cfg_wdata;
				sxd_pkg::REG_SYNC_SECOND: sync_second_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			saw_q <= 1'b0;
			xor_q <= '0;
		end else if (step) begin
			if (pos_q == '0) begin
				if (saw_q && (cur_byte == sync_second_q)) begin
					pos_q <= sxd_pkg::POS_W'(1);
					xor_q <= '0;
					saw_q <= 1'b0;
				end else begin
					saw_q <= (cur_byte == sync_first_q);
				end
			end else if (!at_check) begin
				xor_q <= xor_q ^ cur_byte;
				pos_q <= pos_q + sxd_pkg::POS_W'(1);
			end else begin
				pos_q <= '0;
				saw_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < sxd_pkg::STAMP_BYTES; k++) begin
			if (step && (pos_q == sxd_pkg::POS_W'(k + 1))) begin
				stamp_q[8*k +: 8] <= cur_byte;
			end
		end
		if (cmd.rd_sample_hi) begin
			lo_q <= rd_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q <= '0;
			rp_q   <= '0;
			good_q <= '0;
			bad_q  <= '0;
		end else begin
			if (cmd.accept_in) begin
				chan_q <= '0;
			end else if (cmd.load_good) begin
				chan_q <= chan_q + sxd_pkg::CHAN_W'(1);
			end
			if (cmd.load_err) begin
				rp_q <= '0;
			end else if (cmd.rp_feed) begin
				rp_q <= rp_q + ADDR_W'(1);
			end
			if (status.done_good && (good_q != '1)) begin
				good_q <= good_q + sxd_pkg::COUNT_W'(1);
			end
			if (status.done_bad && (bad_q != '1)) begin
				bad_q <= bad_q + sxd_pkg::COUNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.load_good || cmd.load_err) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_good) begin
			out_kind    <= sxd_pkg::KIND_SAMPLE;
			out_stamp   <= stamp_q;
			out_channel <= chan_q;
			out_sample  <= {rd_data, lo_q};
			out_last    <= status.chan_last;
			out_good    <= good_q;
			out_bad     <= bad_q;
		end else if (cmd.load_err) begin
			out_kind    <= sxd_pkg::KIND_ERROR;
			out_stamp   <= '0;
			out_channel <= '0;
			out_sample  <= '0;
			out_last    <= 1'b1;
			out_good    <= good_q;
			out_bad     <= bad_q;
		end
	end

	assign m_tvalid = m_tvalid_q;

endmodule

[dv/sync_xor_packet_deframer_tb.sv]
// Self-checking testbench for sync_xor_packet_deframer: directed packet plan, then random
// phases of framed, corrupt and noisy byte streams under several sync settings.
// Depends on sxd_pkg and the RTL top level; results are checked against an in-bench predictor.
module sync_xor_packet_deframer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CHANNELS     = 12;
	localparam int STORE_BYTES  = 5 + 2 * CHANNELS;
	localparam int BODY_BYTES   = STORE_BYTES - 1;
	localparam int DRAIN_CYCLES = 80;
	localparam int IDLE_LIMIT   = 2000;
	localparam int RANDOM_ITEMS = 100;
	localparam int PHASES       = 4;
	localparam int PLAN_ROWS    = 22;

	typedef struct packed {
		logic               kind;
		logic [31:0]        stamp;
		logic [3:0]         channel;
		logic signed [15:0] sample;
		logic               last;
		logic [31:0]        good_total;
		logic [31:0]        bad_total;
	} deframe_result_t;

	typedef enum logic [1:0] {EV_NONE, EV_GOOD, EV_BAD} frame_event_t;
	typedef enum logic [1:0] {ROW_BYTE, ROW_SYNC, ROW_BODY, ROW_CFG} row_kind_t;
	typedef enum logic [2:0] {FILL_CONST, FILL_RAMP, FILL_EXTREME, FILL_TAIL, FILL_HIDDEN} fill_t;

	typedef struct packed {
		row_kind_t           kind;
		sxd_pkg::cfg_reg_t   reg_sel;
		fill_t               fill;
		logic [7:0]          value;
		logic [7:0]          flip;
		logic                typed;
		deframe_result_t     result;
	} plan_row_t;

	localparam deframe_result_t NO_RESULT = '0;

	localparam plan_row_t PLAN [PLAN_ROWS] = '{
		'{ROW_BYTE, sxd_pkg::REG_SYNC_FIRST,  FILL_CONST,   8'h00, 8'h00, 1'b0, NO_RESULT},
		'{ROW_BYTE, sxd_pkg::REG_SYNC_FIRST,  FILL_CONST,   8'hFF, 8'h00, 1'b0, NO_RESULT},
		'{ROW_BYTE, sxd_pkg::REG_SYNC_FIRST,  FILL_CONST,   8'hAA, 8'h00, 1'b0, NO_RESULT},
		'{ROW_BYTE, sxd_pkg::REG_SYNC_FIRST,  FILL_CONST,   8'hAA, 8'h00, 1'b0, NO_RESULT},
		'{ROW_BYTE, sxd_pkg::REG_SYNC_FIRST,  FILL_CONST,   8'h55, 8'h00, 1'b0, NO_RESULT},
		'{ROW_BODY, sxd_pkg::REG_SYNC_FIRST,  FILL_CONST,   8'h00, 8'h00, 1'b0, NO_RESULT},
		'{ROW_SYNC, sxd_pkg::REG_SYNC_FIRST,  FILL_CONST,   8'h00, 8'h00, 1'b0, NO_RESULT},
		'{ROW_BODY, sxd_pkg::REG_SYNC_FIRST,  FILL_EXTREME, 8'h00, 8'h00, 1'b0, NO_RESULT},
		'{ROW_SYNC, sxd_pkg::REG_SYNC_FIRST,  FILL_CONST,   8'h00, 8'h00, 1'b0, NO_RESULT},
		'{ROW_BODY, sxd_pkg::REG_SYNC_FIRST,  FILL_RAMP,    8'h01, 8'hFF, 1'b1,
			'{sxd_pkg::KIND_ERROR, 32'd0, 4'd0, 16'sd0, 1'b1, 32'd2, 32'd1}},
		'{ROW_SYNC, sxd_pkg::REG_SYNC_FIRST,  FILL_CONST,   8'h00, 8'h00, 1'b0, NO_RESULT},
		'{ROW_BODY, sxd_pkg::REG_SYNC_FIRST,  FILL_TAIL,    8'hAA, 8'h00, 1'b0, NO_RESULT},
		'{ROW_BYTE, sxd_pkg::REG_SYNC_FIRST,  FILL_CONST,   8'h55, 8'h00, 1'b0, NO_RESULT},
		'{ROW_SYNC, sxd_pkg::REG_SYNC_FIRST,  FILL_CONST,   8'h00, 8'h00, 1'b0, NO_RESULT},
		'{ROW_BODY, sxd_pkg::REG_SYNC_FIRST,  FILL_CONST,   8'h00, 8'h01, 1'b1,
			'{sxd_pkg::KIND_ERROR, 32'd0, 4'd0, 16'sd0, 1'b1, 32'd3, 32'd2}},
		'{ROW_BYTE, sxd_pkg::REG_SYNC_FIRST,  FILL_CONST,   8'hAA, 8'h00, 1'b0, NO_RESULT},
		'{ROW_CFG,  sxd_pkg::REG_SYNC_FIRST,  FILL_CONST,   8'h3C, 8'h00, 1'b0, NO_RESULT},
		'{ROW_CFG,  sxd_pkg::REG_SYNC_SECOND, FILL_CONST,   8'hC3, 8'h00, 1'b0, NO_RESULT},
		'{ROW_BYTE, sxd_pkg::REG_SYNC_FIRST,  FILL_CONST,   8'hC3, 8'h00, 1'b0, NO_RESULT},
		'{ROW_BODY, sxd_pkg::REG_SYNC_FIRST,  FILL_RAMP,    8'h80, 8'h00, 1'b0, NO_RESULT},
		'{ROW_SYNC, sxd_pkg::REG_SYNC_FIRST,  FILL_CONST,   8'h00, 8'h00, 1'b0, NO_RESULT},
		'{ROW_BODY, sxd_pkg::REG_SYNC_FIRST,  FILL_HIDDEN,  8'h11, 8'h40, 1'b1,
			'{sxd_pkg::KIND_ERROR, 32'd0, 4'd0, 16'sd0, 1'b1, 32'd4, 32'd3}}
	};

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          s_tvalid  = 1'b0;
	logic                          s_tready;
	logic [7:0]                    s_tdata   = '0;
	logic                          m_tvalid;
	logic                          m_tready  = 1'b0;
	logic [sxd_pkg::TDATA_W-1:0]   m_tdata;
	logic                          m_tuser;
	logic                          m_tlast;
	logic                          cfg_wr_en = 1'b0;
	sxd_pkg::cfg_reg_t             cfg_index = sxd_pkg::REG_SYNC_FIRST;
	logic [7:0]                    cfg_wdata = '0;

	logic [7:0]           pat_first  = sxd_pkg::SYNC_FIRST_RST;
	logic [7:0]           pat_second = sxd_pkg::SYNC_SECOND_RST;
	logic [7:0]           frame_mem [STORE_BYTES];
	logic [4:0]           frame_pos  = '0;
	logic                 armed      = 1'b0;
	logic [7:0]           csum_acc   = '0;
	logic [31:0]          good_seen  = '0;
	logic [31:0]          bad_seen   = '0;
	deframe_result_t      expected_q [$];
	logic [7:0]           body_buf [BODY_BYTES];

	int mismatches  = 0;
	int idle_cycles = 0;
	int src_calm    = 0;
	int sink_calm   = 0;

	sync_xor_packet_deframer #(
		.CHANNELS(CHANNELS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic frame_event_t hunt_or_store(input logic [7:0] b);
		int slot;
		if (frame_pos == 0) begin
			if (armed && b == pat_second) begin
				frame_pos = 5'd1;
				csum_acc  = '0;
				armed     = 1'b0;
			end else begin
				armed = (b == pat_first);
			end
			return EV_NONE;
		end
		slot = int'(frame_pos) - 1;
		frame_mem[slot] = b;
		if (slot + 1 < STORE_BYTES) begin
			csum_acc  = csum_acc ^ b;
			frame_pos = frame_pos + 5'd1;
			return EV_NONE;
		end
		frame_pos = '0;
		armed     = 1'b0;
		return (b == csum_acc) ? EV_GOOD : EV_BAD;
	endfunction

	task automatic predict_byte(input logic [7:0] b);
		frame_event_t    ev;
		deframe_result_t r;
		logic [7:0]      replay [STORE_BYTES];
		ev = hunt_or_store(b);
		if (ev == EV_GOOD) begin
			if (good_seen != '1)
				good_seen++;
			for (int j = 0; j < CHANNELS; j++) begin
				r.kind       = sxd_pkg::KIND_SAMPLE;
				r.stamp      = {frame_mem[3], frame_mem[2], frame_mem[1], frame_mem[0]};
				r.channel    = 4'(j);
				r.sample     = {frame_mem[5 + 2 * j], frame_mem[4 + 2 * j]};
				r.last       = (j == CHANNELS - 1);
				r.good_total = good_seen;
				r.bad_total  = bad_seen;
				expected_q.push_back(r);
			end
		end else if (ev == EV_BAD) begin
			if (bad_seen != '1)
				bad_seen++;
			expected_q.push_back('{sxd_pkg::KIND_ERROR, 32'd0, 4'd0, 16'sd0, 1'b1,
				good_seen, bad_seen});
			// A sync hidden in the corrupt packet restarts framing from the stored bytes.
			replay = frame_mem;
			foreach (replay[k])
				void'(hunt_or_store(replay[k]));
		end
	endtask

	function automatic int draw_gap(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 9) == 0) begin
			calm = $urandom_range(8, 40);
			return 0;
		end
		return $urandom_range(0, 16);
	endfunction

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = draw_gap(src_calm);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		predict_byte(b);
	endtask

	task automatic send_sync();
		send_byte(pat_first);
		send_byte(pat_second);
	endtask

	task automatic fill_body(input fill_t fill, input logic [7:0] value);
		for (int i = 0; i < BODY_BYTES; i++) begin
			case (fill)
				FILL_RAMP: begin
					body_buf[i] = value + 8'(i);
				end
				FILL_EXTREME: begin
					case (i % 4)
						0:       body_buf[i] = 8'hFF;
						1:       body_buf[i] = 8'h7F;
						2:       body_buf[i] = 8'h00;
						default: body_buf[i] = 8'h80;
					endcase
				end
				FILL_TAIL: begin
					body_buf[i] = (i == BODY_BYTES - 1) ? value : 8'h00;
				end
				default: begin
					body_buf[i] = value;
				end
			endcase
		end
		if (fill == FILL_HIDDEN) begin
			body_buf[2] = pat_first;
			body_buf[3] = pat_second;
		end
	endtask

	task automatic send_body(input logic [7:0] flip);
		logic [7:0] check;
		check = '0;
		foreach (body_buf[i])
			check ^= body_buf[i];
		foreach (body_buf[i])
			send_byte(body_buf[i]);
		send_byte(check ^ flip);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input sxd_pkg::cfg_reg_t sel, input logic [7:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= sel;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (sel == sxd_pkg::REG_SYNC_FIRST)
			pat_first = value;
		else
			pat_second = value;
		@(posedge clk);
	endtask

	task automatic log_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got)
			log_mismatch($sformatf("%s expected 0x%0h, got 0x%0h", name, want, got));
	endtask

	always @(posedge clk) begin
		deframe_result_t got;
		deframe_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{m_tuser, m_tdata[31:0], m_tdata[35:32], m_tdata[51:36], m_tlast,
				m_tdata[83:52], m_tdata[115:84]};
			if (expected_q.size() == 0) begin
				log_mismatch($sformatf("unexpected transfer kind %0d channel %0d",
					got.kind, got.channel));
			end else begin
				want = expected_q.pop_front();
				check_field("kind", 32'(want.kind), 32'(got.kind));
				check_field("stamp", want.stamp, got.stamp);
				check_field("channel", 32'(want.channel), 32'(got.channel));
				check_field("sample", 32'(want.sample), 32'(got.sample));
				check_field("last", 32'(want.last), 32'(got.last));
				check_field("good_total", want.good_total, got.good_total);
				check_field("bad_total", want.bad_total, got.bad_total);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= IDLE_LIMIT) begin
					$display("end of test: mismatches");
					$finish;
				end
			end
		end
	end

	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = draw_gap(sink_calm);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	initial begin
		logic [7:0] first_byte;
		logic [7:0] second_byte;
		int         sent;
		int         pick;
		int         spot;
		int         burst;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (PLAN[r]) begin
			case (PLAN[r].kind)
				ROW_BYTE: begin
					send_byte(PLAN[r].value);
				end
				ROW_SYNC: begin
					send_sync();
				end
				ROW_BODY: begin
					fill_body(PLAN[r].fill, PLAN[r].value);
					send_body(PLAN[r].flip);
					if (PLAN[r].typed && expected_q.size() != 0)
						expected_q[expected_q.size() - 1] = PLAN[r].result;
				end
				default: begin
					settle();
					write_reg(PLAN[r].reg_sel, PLAN[r].value);
				end
			endcase
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin
					first_byte  = 8'h00;
					second_byte = 8'hFF;
				end
				1: begin
					first_byte  = 8'hFF;
					second_byte = 8'h00;
				end
				2: begin
					first_byte  = 8'($urandom_range(0, 255));
					second_byte = first_byte;
				end
				default: begin
					first_byte  = 8'($urandom_range(0, 255));
					second_byte = 8'($urandom_range(0, 255));
				end
			endcase
			settle();
			write_reg(sxd_pkg::REG_SYNC_FIRST, first_byte);
			write_reg(sxd_pkg::REG_SYNC_SECOND, second_byte);
			sent = 0;
			while (sent < RANDOM_ITEMS / PHASES) begin
				pick = $urandom_range(0, 19);
				if (pick >= 18) begin
					burst = $urandom_range(1, 6);
					repeat (burst)
						send_byte(8'($urandom_range(0, 255)));
					sent += burst;
				end else begin
					foreach (body_buf[i])
						body_buf[i] = 8'($urandom_range(0, 255));
					if (pick >= 16) begin
						spot = $urandom_range(0, BODY_BYTES - 2);
						body_buf[spot]     = pat_first;
						body_buf[spot + 1] = pat_second;
					end
					send_sync();
					send_body((pick >= 13) ? 8'($urandom_range(1, 255)) : 8'h00);
					sent += 2 + STORE_BYTES;
				end
			end
		end

		settle();
		if (expected_q.size() != 0)
			log_mismatch("results still outstanding at the end");
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

[files.f]
rtl/sxd_pkg.sv
rtl/sxd_ram.sv
rtl/sxd_ctrl.sv
rtl/sxd_datapath.sv
rtl/sync_xor_packet_deframer.sv
dv/sync_xor_packet_deframer_tb.sv
